>>> src/gdd_pkg.sv
//------------------------------------------------------------------------------
// gdd_pkg
// Shared types and constants of the guitar distortion and delay chain.
//------------------------------------------------------------------------------
package gdd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 24;
    localparam int ALPHA_Q15 = 27853;
    localparam int BETA_Q15  = 1638;
    localparam int CLIP_Q22  = 1677722;

    localparam logic [2:0] REG_OD_EN   = 3'd0;
    localparam logic [2:0] REG_DIST_EN = 3'd1;
    localparam logic [2:0] REG_DLY_EN  = 3'd2;
    localparam logic [2:0] REG_DLY_LEN = 3'd3;
    localparam logic [2:0] REG_MIX     = 3'd4;
    localparam logic [2:0] REG_FB      = 3'd5;

    // multiply request to the serial multiplier
    typedef struct packed {
        logic               start;
        logic signed [39:0] a;
        logic        [15:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [55:0] p;
    } mul_rsp_t;

    function automatic logic [14:0] tanh_lut(input logic [4:0] k);
        logic [14:0] v;
        begin
            case (k)
                5'd0:  v = 15'd0;
                5'd1:  v = 15'd9919;
                5'd2:  v = 15'd18173;
                5'd3:  v = 15'd24054;
                5'd4:  v = 15'd27797;
                5'd5:  v = 15'd30010;
                5'd6:  v = 15'd31262;
                5'd7:  v = 15'd31953;
                5'd8:  v = 15'd32329;
                5'd9:  v = 15'd32533;
                5'd10: v = 15'd32642;
                5'd11: v = 15'd32700;
                5'd12: v = 15'd32732;
                5'd13: v = 15'd32749;
                5'd14: v = 15'd32758;
                5'd15: v = 15'd32762;
                default: v = 15'd32765;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/gdd_serial_mul.sv
//------------------------------------------------------------------------------
// gdd_serial_mul
// Shift-and-add multiplier: signed 40-bit by unsigned 16-bit, one bit a cycle.
//------------------------------------------------------------------------------
module gdd_serial_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  gdd_pkg::mul_req_t req,
    output gdd_pkg::mul_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [55:0] acc_reg, acc_next;
    logic signed [55:0] mcand_reg, mcand_next;
    logic [15:0]        mplier_reg, mplier_next;
    logic               done_reg, done_next;

    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        done_next   = 1'b0;
        if (req.start) begin
            busy_next   = 1'b1;
            cnt_next    = 5'd0;
            acc_next    = '0;
            mcand_next  = 56'(req.a);
            mplier_next = req.b;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

>>> src/guitar_distortion_delay_chain.sv
// Processing: with all stages on, a sample takes seven 16-bit multiplier passes plus
//   the steps between them; with all stages off, it takes no multiplier pass.
// Flow: one transaction at a time; the next is taken only after the result
//   is taken and the block has returned to idle.
// Reset: synchronous, active low; registers to defaults, filter state and write
//   pointers to zero; then the delay memory is cleared before the first input is taken.
//------------------------------------------------------------------------------
// guitar_distortion_delay_chain
// Overdrive, distortion and feedback delay for up to two channels.
//------------------------------------------------------------------------------
module guitar_distortion_delay_chain #(
    parameter int DELAY_DEPTH   = 32768,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] in_sample
    input  logic        s_tuser,   // [0] channel_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] out_sample
    output logic        m_tuser,   // [0] out_channel
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MD  = CHANNEL_COUNT * DELAY_DEPTH;
    localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_OD    = 5'd2;
    localparam logic [4:0] ST_ODW   = 5'd3;
    localparam logic [4:0] ST_SM    = 5'd4;
    localparam logic [4:0] ST_SMW   = 5'd5;
    localparam logic [4:0] ST_GN    = 5'd6;
    localparam logic [4:0] ST_GNW   = 5'd7;
    localparam logic [4:0] ST_LP    = 5'd8;
    localparam logic [4:0] ST_LPW   = 5'd9;
    localparam logic [4:0] ST_DRD   = 5'd10;
    localparam logic [4:0] ST_DRD2  = 5'd11;
    localparam logic [4:0] ST_M1    = 5'd12;
    localparam logic [4:0] ST_M1W   = 5'd13;
    localparam logic [4:0] ST_M2W   = 5'd14;
    localparam logic [4:0] ST_M3W   = 5'd15;
    localparam logic [4:0] ST_DWR   = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;

    // configuration
    logic        od_en_reg, dist_en_reg, dly_en_reg;
    logic [14:0] dly_len_reg, fb_reg;
    logic [15:0] mix_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            od_en_reg   <= 1'b0;
            dist_en_reg <= 1'b0;
            dly_en_reg  <= 1'b0;
            dly_len_reg <= 15'd22050;
            mix_reg     <= 16'd16384;
            fb_reg      <= 15'd16384;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            case (paddr[4:2])
                gdd_pkg::REG_OD_EN:   od_en_reg   <= pwdata[0];
                gdd_pkg::REG_DIST_EN: dist_en_reg <= pwdata[0];
                gdd_pkg::REG_DLY_EN:  dly_en_reg  <= pwdata[0];
                gdd_pkg::REG_DLY_LEN: dly_len_reg <= pwdata[14:0];
                gdd_pkg::REG_MIX:     mix_reg     <= pwdata[15:0];
                gdd_pkg::REG_FB:      fb_reg      <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gdd_pkg::REG_OD_EN:   prdata = {31'd0, od_en_reg};
            gdd_pkg::REG_DIST_EN: prdata = {31'd0, dist_en_reg};
            gdd_pkg::REG_DLY_EN:  prdata = {31'd0, dly_en_reg};
            gdd_pkg::REG_DLY_LEN: prdata = {17'd0, dly_len_reg};
            gdd_pkg::REG_MIX:     prdata = {16'd0, mix_reg};
            gdd_pkg::REG_FB:      prdata = {17'd0, fb_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // datapath state
    logic [4:0]         st_reg, st_next;
    logic [MAW-1:0]     clr_reg, clr_next;
    logic signed [23:0] x_reg, x_next;      // working sample, 16 bit range
    logic               chin_reg, chin_next;
    logic [CW-1:0]      ch_reg, ch_next;
    logic signed [23:0] s_reg, s_next;      // smoother value
    logic signed [23:0] g_reg, g_next;
    logic signed [23:0] d_reg, d_next;
    logic signed [39:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [14:0]        base_reg, base_next;
    logic signed [23:0] sm_st  [CHANNEL_COUNT];
    logic signed [23:0] lp_st  [CHANNEL_COUNT];
    logic [AW-1:0]      wp_st  [CHANNEL_COUNT];
    logic               sm_we, lp_we, wp_we;
    logic signed [23:0] sm_wd, lp_wd;

    // delay memory
    logic signed [15:0] dmem [MD];
    logic signed [15:0] rd_reg;
    logic [MAW-1:0]     raddr, waddr;
    logic               mwe;
    logic signed [15:0] mwd;

    gdd_pkg::mul_req_t mreq;
    gdd_pkg::mul_rsp_t mrsp;

    gdd_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607) return 24'sh7FFFFF;
        if (v < -40'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic signed [23:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) return 24'sd32767;
        if (v < -40'sd32768) return -24'sd32768;
        return v[23:0];
    endfunction

    logic [AW:0]        rp_wide;
    logic [AW-1:0]      lag, rp, wp_cur;
    logic [15:0]        mix_c;
    logic [15:0]        mag;
    logic [4:0]         tidx;
    logic signed [55:0] pr;
    logic signed [39:0] rnd15, sum40;

    assign wp_cur  = wp_st[ch_reg];
    assign lag     = AW'(32'(dly_len_reg) % DELAY_DEPTH);
    assign rp_wide = {1'b0, wp_cur} + (AW+1)'(DELAY_DEPTH) - {1'b0, lag};
    assign rp      = (rp_wide >= (AW+1)'(DELAY_DEPTH)) ?
                     AW'(rp_wide - (AW+1)'(DELAY_DEPTH)) : rp_wide[AW-1:0];
    assign mix_c   = mix_reg[15] ? 16'd32768 : mix_reg;
    assign mag     = x_reg[15] ? 16'(-x_reg[15:0]) : x_reg[15:0];
    assign tidx    = mag[15:11];
    assign pr      = mrsp.p;
    assign rnd15   = 40'((pr + 56'sd16384) >>> 15);

    always_comb begin
        st_next = st_reg; clr_next = clr_reg; x_next = x_reg;
        chin_next = chin_reg; ch_next = ch_reg; s_next = s_reg; g_next = g_reg;
        d_next = d_reg; acc_next = acc_reg; neg_next = neg_reg; base_next = base_reg;
        sm_we = 1'b0; lp_we = 1'b0; wp_we = 1'b0; sm_wd = s_reg; lp_wd = '0;
        mwe = 1'b0; mwd = '0;
        waddr = MAW'(ch_reg) * MAW'(DELAY_DEPTH) + MAW'(wp_cur);
        raddr = MAW'(ch_reg) * MAW'(DELAY_DEPTH) + MAW'(rp);
        mreq = '0;
        sum40 = '0;
        case (st_reg)
            ST_CLEAR: begin
                mwe = 1'b1; waddr = clr_reg;
                clr_next = clr_reg + MAW'(1);
                if (clr_reg == MAW'(MD - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next    = 24'(signed'(s_tdata));
                    chin_next = s_tuser;
                    ch_next   = (32'(s_tuser) >= CHANNEL_COUNT) ?
                                CW'(CHANNEL_COUNT - 1) : CW'(s_tuser);
                    st_next   = ST_OD;
                end
            end
            ST_OD: begin
                if (!od_en_reg) st_next = ST_SM;
                else if (tidx >= 5'd16) begin
                    x_next  = x_reg[15] ? -24'sd32765 : 24'sd32765;
                    st_next = ST_SM;
                end else begin
                    neg_next  = x_reg[15];
                    base_next = gdd_pkg::tanh_lut(tidx);
                    mreq.start = 1'b1;
                    mreq.a = 40'(gdd_pkg::tanh_lut(tidx + 5'd1) - gdd_pkg::tanh_lut(tidx));
                    mreq.b = {5'd0, mag[10:0]};
                    st_next = ST_ODW;
                end
            end
            ST_ODW: if (mrsp.done) begin
                sum40  = 40'(base_reg) + 40'((pr + 56'sd1024) >>> 11);
                x_next = neg_reg ? -sum40[23:0] : sum40[23:0];
                st_next = ST_SM;
            end
            ST_SM: begin
                if (!dist_en_reg) st_next = ST_DRD;
                else begin
                    mreq.start = 1'b1;
                    mreq.a = 40'(sm_st[ch_reg]) - 40'(x_reg <<< 7);
                    mreq.b = 16'(gdd_pkg::ALPHA_Q15);
                    st_next = ST_SMW;
                end
            end
            ST_SMW: if (mrsp.done) begin
                s_next = sat24(40'(x_reg <<< 7) + rnd15);
                sm_we = 1'b1; sm_wd = s_next;
                st_next = ST_GN;
            end
            ST_GN: begin
                mreq.start = 1'b1;
                mreq.a = 40'(s_reg);
                mreq.b = 16'd12;
                st_next = ST_GNW;
            end
            ST_GNW: if (mrsp.done) begin
                if (pr > 56'(gdd_pkg::CLIP_Q22)) g_next = 24'(gdd_pkg::CLIP_Q22);
                else if (pr < -56'(gdd_pkg::CLIP_Q22)) g_next = -24'(gdd_pkg::CLIP_Q22);
                else g_next = pr[23:0];
                st_next = ST_LP;
            end
            ST_LP: begin
                mreq.start = 1'b1;
                mreq.a = 40'(g_reg) - 40'(lp_st[ch_reg]);
                mreq.b = 16'(gdd_pkg::BETA_Q15);
                st_next = ST_LPW;
            end
            ST_LPW: if (mrsp.done) begin
                lp_wd = sat24(40'(lp_st[ch_reg]) + rnd15);
                lp_we = 1'b1;
                x_next = sat16((40'(lp_wd) * 2 + 40'sd64) >>> 7);
                st_next = ST_DRD;
            end
            ST_DRD: st_next = dly_en_reg ? ST_DRD2 : ST_OUT;
            ST_DRD2: begin
                d_next = 24'(rd_reg);
                st_next = ST_M1;
            end
            ST_M1: begin
                mreq.start = 1'b1;
                mreq.a = 40'(x_reg);
                mreq.b = 16'd32768 - mix_c;
                st_next = ST_M1W;
            end
            ST_M1W: if (mrsp.done) begin
                acc_next = 40'(pr);
                mreq.start = 1'b1;
                mreq.a = 40'(d_reg);
                mreq.b = mix_c;
                st_next = ST_M2W;
            end
            ST_M2W: if (mrsp.done) begin
                acc_next = 40'((56'(acc_reg) + pr + 56'sd16384) >>> 15);
                mreq.start = 1'b1;
                mreq.a = 40'(d_reg);
                mreq.b = {1'b0, fb_reg};
                st_next = ST_M3W;
            end
            ST_M3W: if (mrsp.done) begin
                g_next = sat16(40'(x_reg) + rnd15);
                x_next = sat16(acc_reg);
                st_next = ST_DWR;
            end
            ST_DWR: begin
                mwe = 1'b1; mwd = g_reg[15:0];
                wp_we = 1'b1;
                st_next = ST_OUT;
            end
            ST_OUT: if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                sm_st[i] <= '0;
                lp_st[i] <= '0;
                wp_st[i] <= '0;
            end
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            if (sm_we) sm_st[ch_reg] <= sm_wd;
            if (lp_we) lp_st[ch_reg] <= lp_wd;
            if (wp_we) wp_st[ch_reg] <= (32'(wp_cur) == DELAY_DEPTH - 1) ?
                                        '0 : wp_cur + AW'(1);
        end
        x_reg <= x_next; chin_reg <= chin_next; ch_reg <= ch_next;
        s_reg <= s_next; g_reg <= g_next; d_reg <= d_next;
        acc_reg <= acc_next; neg_reg <= neg_next; base_reg <= base_next;
    end

    always_ff @(posedge aclk) begin
        if (mwe) dmem[waddr] <= mwd;
        rd_reg <= dmem[raddr];
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = x_reg[15:0];
    assign m_tuser  = chin_reg;

`ifndef ASSERT_OFF
    a_no_dual: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second sample taken");
`endif

endmodule
